// ----- sv/fvn_pkg.sv -----
// ----------------------------------------------------------------------------
// fvn_pkg: shared constants and types for the fractal value noise unit
// Widths of the octave lanes, hash constants, register map and sequencer states.
// ----------------------------------------------------------------------------
package fvn_pkg;

    localparam int MAX_OCTAVES_DEF = 8;

    // Q36.16 frequency after lacunarity steps keeps 52 significant bits
    localparam int FREQ_W   = 52;
    localparam int FREQ_LO_W = 26;
    localparam int AMP_W    = 17;
    localparam int TERM_W   = 36;
    localparam int QUO_W    = 17;
    localparam int LANE_LAT = 9;

    localparam logic [31:0] HASH_MUL_Y   = 32'd137;
    localparam logic [31:0] HASH_MUL_S   = 32'd13;
    localparam logic [31:0] HASH_MUL_SQ  = 32'd15731;
    localparam logic [31:0] HASH_ADD_SQ  = 32'd789221;
    localparam logic [31:0] HASH_ADD_OUT = 32'd1376312589;

    localparam logic [FREQ_W-1:0] FREQ_ONE = FREQ_W'(65536);
    localparam logic [AMP_W-1:0]  AMP_ONE  = AMP_W'(65536);

    localparam logic [1:0] REG_OCTAVES     = 2'd0;
    localparam logic [1:0] REG_PERSISTENCE = 2'd1;
    localparam logic [1:0] REG_LACUNARITY  = 2'd2;
    localparam logic [1:0] REG_SEED        = 2'd3;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_INIT,
        SEQ_RUN
    } seq_state_t;

endpackage

// ----- sv/fvn_octave.sv -----
// ----------------------------------------------------------------------------
// fvn_octave: one octave lane of the noise pipeline
// Scales the point, hashes the four lattice corners, blends them bilinearly
// and weights the result by the octave amplitude. Nine register stages.
// ----------------------------------------------------------------------------
module fvn_octave
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [31:0]                coord_x,
    input  logic signed [31:0]                coord_y,
    input  logic [fvn_pkg::FREQ_W-1:0]        freq,
    input  logic [fvn_pkg::AMP_W-1:0]         amp,
    input  logic [31:0]                       seed_term,
    output logic signed [fvn_pkg::TERM_W-1:0] term
);

    localparam int FLW = fvn_pkg::FREQ_LO_W;
    localparam int PPW = 32 + FLW + 1;

    function automatic logic [31:0] hash_mix(input logic [31:0] ix, input logic [31:0] iy,
                                             input logic [31:0] st);
        logic [31:0] h;
        h = ix + iy * fvn_pkg::HASH_MUL_Y + st;
        return (h << 13) ^ h;
    endfunction

    function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] t);
        logic [32:0] acc;
        acc = 33'(a) * 33'(17'h10000 - 17'(t)) + 33'(b) * 33'(t);
        return acc[31:16];
    endfunction

    logic signed [PPW-1:0] xl_reg, xh_reg, yl_reg, yh_reg;
    logic [63:0]           px, py;
    logic [31:0]           xi_reg, yi_reg;
    logic [15:0]           xf_reg, yf_reg;
    logic [31:0]           h_reg   [0:3];
    logic [31:0]           h4_reg  [0:3];
    logic [31:0]           hh_reg  [0:3];
    logic [31:0]           h5_reg  [0:3];
    logic [31:0]           t_reg   [0:3];
    logic [31:0]           g_reg   [0:3];
    logic [15:0]           sx3_reg, sy3_reg, sx4_reg, sy4_reg, sx5_reg, sy5_reg;
    logic [15:0]           sx6_reg, sy6_reg, sy7_reg;
    logic [15:0]           row0_reg, row1_reg, v_reg;
    logic [31:0]           xi1, yi1;
    logic signed [17:0]    n_val;

    // stage 1: point times frequency, split in two partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xl_reg <= coord_x * $signed({1'b0, freq[FLW-1:0]});
            xh_reg <= coord_x * $signed({1'b0, freq[fvn_pkg::FREQ_W-1:FLW]});
            yl_reg <= coord_y * $signed({1'b0, freq[FLW-1:0]});
            yh_reg <= coord_y * $signed({1'b0, freq[fvn_pkg::FREQ_W-1:FLW]});
        end
    end

    // stage 2: recombine modulo 2^64; lattice cell and fraction
    assign px = 64'(xl_reg) + (64'(xh_reg) << FLW);
    assign py = 64'(yl_reg) + (64'(yh_reg) << FLW);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xi_reg <= px[63:32];
            yi_reg <= py[63:32];
            xf_reg <= px[31:16];
            yf_reg <= py[31:16];
        end
    end

    // stage 3..6: corner hashes (00, 10, 01, 11)
    assign xi1 = xi_reg + 32'd1;
    assign yi1 = yi_reg + 32'd1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg[0] <= hash_mix(xi_reg, yi_reg, seed_term);
            h_reg[1] <= hash_mix(xi1, yi_reg, seed_term);
            h_reg[2] <= hash_mix(xi_reg, yi1, seed_term);
            h_reg[3] <= hash_mix(xi1, yi1, seed_term);
            sx3_reg  <= xf_reg;
            sy3_reg  <= yf_reg;
            for (int c = 0; c < 4; c++)
            begin
                hh_reg[c] <= h_reg[c] * h_reg[c];
                h4_reg[c] <= h_reg[c];
                t_reg[c]  <= hh_reg[c] * fvn_pkg::HASH_MUL_SQ + fvn_pkg::HASH_ADD_SQ;
                h5_reg[c] <= h4_reg[c];
                g_reg[c]  <= h5_reg[c] * t_reg[c] + fvn_pkg::HASH_ADD_OUT;
            end
            sx4_reg <= sx3_reg;
            sy4_reg <= sy3_reg;
            sx5_reg <= sx4_reg;
            sy5_reg <= sy4_reg;
            sx6_reg <= sx5_reg;
            sy6_reg <= sy5_reg;
        end
    end

    // stage 7..9: bilinear blend, map to -1..1, weight by amplitude
    assign n_val = $signed({1'b0, v_reg, 1'b0}) - 18'sd65536;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row0_reg <= lerp16(g_reg[0][30:15], g_reg[1][30:15], sx6_reg);
            row1_reg <= lerp16(g_reg[2][30:15], g_reg[3][30:15], sx6_reg);
            sy7_reg  <= sy6_reg;
            v_reg    <= lerp16(row0_reg, row1_reg, sy7_reg);
            term     <= n_val * $signed({1'b0, amp});
        end
    end

endmodule

// ----- sv/fractal_value_noise_2d_unit.sv -----
// ----------------------------------------------------------------------------
// fractal_value_noise_2d_unit: multi-octave 2D value noise, Q16.16 in, Q1.15 out
// Octave lanes in parallel, a registered adder tree, then a bit-per-stage divider.
// ----------------------------------------------------------------------------
// Register stages from input transaction to m_tvalid: 9 lane, adder tree, 1 abs,
//   17 divide, 1 output stage. Throughput: one point per clock while s_tready is
//   high; the divider retires one quotient bit per stage.
// Reset and every register write rebuild the per-octave frequency/amplitude tables:
//   s_tready stays low until the sequencer returns to SEQ_IDLE.
module fractal_value_noise_2d_unit
#(
    parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] coord_x, [63:32] coord_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] noise_value
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LV   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 0;
    localparam int LVD  = (LV > 0) ? LV : 1;
    localparam int P    = 1 << LV;
    localparam int KW   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
    localparam int SUMW = fvn_pkg::AMP_W + $clog2(MAX_OCTAVES);
    localparam int DW   = SUMW + 1;
    localparam int TW   = fvn_pkg::TERM_W + LV;
    localparam int QW   = fvn_pkg::QUO_W;
    localparam int CW   = ((TW > DW + QW) ? TW : DW + QW) + 1;
    localparam int NV   = fvn_pkg::LANE_LAT + LV + 1 + QW;
    localparam int FW   = fvn_pkg::FREQ_W;
    localparam int AW   = fvn_pkg::AMP_W;

    // configuration registers
    logic [3:0]  octave_count_reg;
    logic [15:0] persistence_reg;
    logic [15:0] lacunarity_reg;
    logic [31:0] noise_seed_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    // table sequencer
    fvn_pkg::seq_state_t state_reg, state_next;
    logic [KW-1:0]   k_reg;
    logic [FW-1:0]   freq_run_reg;
    logic [AW-1:0]   amp_run_reg;
    logic [31:0]     s13_run_reg;
    logic [SUMW-1:0] sum_reg;
    logic [FW-1:0]   freq_tab_reg [0:MAX_OCTAVES-1];
    logic [AW-1:0]   amp_tab_reg  [0:MAX_OCTAVES-1];
    logic [31:0]     s13_tab_reg  [0:MAX_OCTAVES-1];
    logic [4:0]      cnt_eff;
    logic            k_active;
    logic [FW+15:0]  freq_prod;
    logic [AW+15:0]  amp_prod;

    // datapath
    logic                            en;
    logic                            in_acc;
    logic [NV-1:0]                   vld_reg;
    logic signed [fvn_pkg::TERM_W-1:0] term [0:MAX_OCTAVES-1];
    logic signed [TW-1:0]            lvl0 [0:P-1];
    logic signed [TW-1:0]            tr_reg [1:LVD][0:P-1];
    logic signed [TW-1:0]            total;
    logic [DW-1:0]                   dvsr;
    logic                            neg_reg [0:QW];
    logic [CW-1:0]                   rem_reg [0:QW];
    logic [QW-1:0]                   quo_reg [0:QW];
    logic [15:0]                     result;
    logic                            out_vld_reg, skid_vld_reg;
    logic [15:0]                     out_data_reg, skid_data_reg;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg <= 4'd4;
            persistence_reg  <= 16'd32768;
            lacunarity_reg   <= 16'd8192;
            noise_seed_reg   <= 32'd0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                fvn_pkg::REG_OCTAVES:     octave_count_reg <= pwdata[3:0];
                fvn_pkg::REG_PERSISTENCE: persistence_reg  <= pwdata[15:0];
                fvn_pkg::REG_LACUNARITY:  lacunarity_reg   <= pwdata[15:0];
                fvn_pkg::REG_SEED:        noise_seed_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            fvn_pkg::REG_OCTAVES:     prdata = {28'd0, octave_count_reg};
            fvn_pkg::REG_PERSISTENCE: prdata = {16'd0, persistence_reg};
            fvn_pkg::REG_LACUNARITY:  prdata = {16'd0, lacunarity_reg};
            fvn_pkg::REG_SEED:        prdata = noise_seed_reg;
            default:                  prdata = 32'd0;
        endcase
    end

    // ---------------- per-octave table sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fvn_pkg::SEQ_INIT;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == fvn_pkg::SEQ_RUN)
                k_reg <= k_reg + KW'(1);
            else
                k_reg <= '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fvn_pkg::SEQ_IDLE:
                if (cfg_wr)
                    state_next = fvn_pkg::SEQ_INIT;
            fvn_pkg::SEQ_INIT:
                if (!cfg_wr)
                    state_next = fvn_pkg::SEQ_RUN;
            fvn_pkg::SEQ_RUN:
                if (cfg_wr)
                    state_next = fvn_pkg::SEQ_INIT;
                else if (k_reg == KW'(MAX_OCTAVES - 1))
                    state_next = fvn_pkg::SEQ_IDLE;
            default:
                state_next = fvn_pkg::SEQ_INIT;
        endcase
    end

    // zero octaves act as one, too many are clamped
    always_comb
    begin
        cnt_eff = {1'b0, octave_count_reg};
        if (cnt_eff == 5'd0)
            cnt_eff = 5'd1;
        if (cnt_eff > 5'(MAX_OCTAVES))
            cnt_eff = 5'(MAX_OCTAVES);
    end

    assign k_active  = 5'(k_reg) < cnt_eff;
    assign freq_prod = freq_run_reg * lacunarity_reg;
    assign amp_prod  = amp_run_reg * persistence_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == fvn_pkg::SEQ_INIT)
        begin
            freq_run_reg <= fvn_pkg::FREQ_ONE;
            amp_run_reg  <= fvn_pkg::AMP_ONE;
            s13_run_reg  <= noise_seed_reg * fvn_pkg::HASH_MUL_S;
            sum_reg      <= '0;
        end
        else if (state_reg == fvn_pkg::SEQ_RUN)
        begin
            freq_tab_reg[k_reg] <= freq_run_reg;
            amp_tab_reg[k_reg]  <= k_active ? amp_run_reg : '0;
            s13_tab_reg[k_reg]  <= s13_run_reg;
            if (k_active)
                sum_reg <= sum_reg + SUMW'(amp_run_reg);
            // frequency product wraps at 64 bits, then drops 12 fraction bits
            freq_run_reg <= freq_prod[63:12];
            amp_run_reg  <= amp_prod[AW+15:16];
            s13_run_reg  <= s13_run_reg + fvn_pkg::HASH_MUL_S;
        end
    end

    // ---------------- pipeline control ----------------
    assign en       = ~skid_vld_reg;
    assign s_tready = en & (state_reg == fvn_pkg::SEQ_IDLE);
    assign in_acc   = s_tvalid & s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NV-2:0], in_acc};
    end

    // ---------------- octave lanes ----------------
    for (genvar k = 0; k < MAX_OCTAVES; k++)
    begin : g_lane
        fvn_octave u_octave
        (
            .clk       (clk),
            .en        (en),
            .coord_x   (s_tdata[31:0]),
            .coord_y   (s_tdata[63:32]),
            .freq      (freq_tab_reg[k]),
            .amp       (amp_tab_reg[k]),
            .seed_term (s13_tab_reg[k]),
            .term      (term[k])
        );
    end

    // ---------------- adder tree ----------------
    for (genvar k = 0; k < P; k++)
    begin : g_leaf
        if (k < MAX_OCTAVES)
        begin : g_used
            assign lvl0[k] = TW'(term[k]);
        end
        else
        begin : g_pad
            assign lvl0[k] = '0;
        end
    end

    for (genvar lev = 1; lev <= LV; lev++)
    begin : g_level
        for (genvar j = 0; j < (P >> lev); j++)
        begin : g_node
            if (lev == 1)
            begin : g_first
                always_ff @(posedge clk)
                begin
                    if (en)
                        tr_reg[lev][j] <= lvl0[2*j] + lvl0[2*j+1];
                end
            end
            else
            begin : g_upper
                always_ff @(posedge clk)
                begin
                    if (en)
                        tr_reg[lev][j] <= tr_reg[lev-1][2*j] + tr_reg[lev-1][2*j+1];
                end
            end
        end
    end

    if (LV == 0)
    begin : g_tot_leaf
        assign total = lvl0[0];
    end
    else
    begin : g_tot_tree
        assign total = tr_reg[LVD][0];
    end

    // ---------------- signed division by twice the amplitude sum ----------------
    assign dvsr = {sum_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= total[TW-1];
            rem_reg[0] <= total[TW-1] ? (CW'(0) - CW'(total)) : CW'(total);
            quo_reg[0] <= '0;
        end
    end

    for (genvar j = 1; j <= QW; j++)
    begin : g_div
        localparam int B = QW - j;
        logic [CW-1:0] dsh;
        assign dsh = CW'(dvsr) << B;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[j] <= neg_reg[j-1];
                if (rem_reg[j-1] >= dsh)
                begin
                    rem_reg[j] <= rem_reg[j-1] - dsh;
                    quo_reg[j] <= quo_reg[j-1] | (QW'(1) << B);
                end
                else
                begin
                    rem_reg[j] <= rem_reg[j-1];
                    quo_reg[j] <= quo_reg[j-1];
                end
            end
        end
    end

    // quotient magnitude never exceeds 32768; only the positive side saturates
    always_comb
    begin
        if (neg_reg[QW])
            result = 16'(QW'(0) - quo_reg[QW]);
        else if (quo_reg[QW][QW-1])
            result = 16'h7fff;
        else
            result = quo_reg[QW][15:0];
    end

    // ---------------- output register and skid stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (m_tready)
                skid_vld_reg <= 1'b0;
        end
        else if (vld_reg[NV-1])
        begin
            if (out_vld_reg && !m_tready)
                skid_vld_reg <= 1'b1;
            else
                out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (m_tready)
                out_data_reg <= skid_data_reg;
        end
        else if (vld_reg[NV-1])
        begin
            if (out_vld_reg && !m_tready)
                skid_data_reg <= result;
            else
                out_data_reg <= result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- sv/fvn_checker.sv -----
// ----------------------------------------------------------------------------
// fvn_checker: port-level checks for the fractal value noise unit
// Output hold under back-pressure, table rebuild after writes, APB ready.
// ----------------------------------------------------------------------------
module fvn_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic        pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a register write restarts the table rebuild, so no input transaction next cycle
    a_wr_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready |=> !s_tready)
        else $error("input taken during table rebuild");

    a_apb_ready: assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("pready low");

endmodule

bind fractal_value_noise_2d_unit fvn_checker u_fvn_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready)
);

// ----- dv/fractal_value_noise_2d_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractal_value_noise_2d_unit_test: self-checking bench for the noise unit
// Streams Q16.16 points through several register settings, predicts each
// noise sample in the bench and checks results in order under random stalls.
// ----------------------------------------------------------------------------
module fractal_value_noise_2d_unit_test;

    localparam int OCT_LIMIT  = 8;
    localparam int IDLE_LIMIT = 3000;
    localparam int SETTLE     = 45;

    class noise_scoreboard;
        logic [15:0] expected_noise[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        task report(string what);
            $display("%0t mismatch: %s", $time, what);
            errors++;
        endtask

        function void note_point(logic [15:0] v);
            expected_noise.push_back(v);
        endfunction

        task check_sample(logic [15:0] got);
            logic [15:0] want;
            if (expected_noise.size() == 0)
                report($sformatf("unexpected noise_value %h", got));
            else
            begin
                want = expected_noise.pop_front();
                if (got !== want)
                    report($sformatf("noise_value %h, expected %h", got, want));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [31:0] coord_x, [63:32] coord_y
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] noise_value
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [3:0]  octaves_q;
    logic [15:0] persist_q;
    logic [15:0] lacun_q;
    logic [31:0] seed_q;

    noise_scoreboard sb;
    bit              calm;
    int              idle_cycles;
    int              stall_left;

    fractal_value_noise_2d_unit dut
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic [31:0] lattice_hash(logic [31:0] ix, logic [31:0] iy,
                                                 logic [31:0] s);
        logic [31:0] h;
        h = ix + iy * fvn_pkg::HASH_MUL_Y + s * fvn_pkg::HASH_MUL_S;
        h = (h << 13) ^ h;
        h = h * (h * h * fvn_pkg::HASH_MUL_SQ + fvn_pkg::HASH_ADD_SQ) + fvn_pkg::HASH_ADD_OUT;
        return {1'b0, h[30:0]};
    endfunction

    function automatic logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [63:0] t);
        return (a * (64'd65536 - t) + b * t) >> 16;
    endfunction

    function automatic logic [15:0] noise_at(logic [31:0] cx, logic [31:0] cy);
        logic [63:0]        ux, uy, freq, amp, amp_sum, px, py, r0, r1, v;
        logic [31:0]        x0, y0, s;
        logic signed [63:0] total, n, q;
        int                 cnt;
        ux = {{32{cx[31]}}, cx};
        uy = {{32{cy[31]}}, cy};
        cnt = (octaves_q == 0) ? 1 : (octaves_q > OCT_LIMIT) ? OCT_LIMIT : octaves_q;
        freq = 64'd65536;
        amp = 64'd65536;
        amp_sum = 0;
        total = 0;
        for (int i = 0; i < cnt; i++)
        begin
            px = ux * freq;
            py = uy * freq;
            x0 = px[63:32];
            y0 = py[63:32];
            s = seed_q + i;
            r0 = blend(64'(lattice_hash(x0, y0, s) >> 15),
                       64'(lattice_hash(x0 + 1, y0, s) >> 15), 64'(px[31:16]));
            r1 = blend(64'(lattice_hash(x0, y0 + 1, s) >> 15),
                       64'(lattice_hash(x0 + 1, y0 + 1, s) >> 15), 64'(px[31:16]));
            v = blend(r0, r1, 64'(py[31:16]));
            n = $signed(2 * v) - 64'sd65536;
            total += n * $signed(amp);
            amp_sum += amp;
            amp = (amp * persist_q) >> 16;
            freq = (freq * lacun_q) >> 12;
        end
        q = total / $signed(2 * amp_sum);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // sink side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            stall_left <= gap_len();
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_sample(m_tdata);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("fractal_value_noise_2d_unit_test: errors");
            $finish;
        end
    end

    task reg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            fvn_pkg::REG_OCTAVES:     octaves_q = val[3:0];
            fvn_pkg::REG_PERSISTENCE: persist_q = val[15:0];
            fvn_pkg::REG_LACUNARITY:  lacun_q = val[15:0];
            fvn_pkg::REG_SEED:        seed_q = val;
            default:                  ;
        endcase
    endtask

    task drain();
        while (sb.expected_noise.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task send_point(logic [31:0] cx, logic [31:0] cy);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {cy, cx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_point(noise_at(cx, cy));
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(0, 20'hfffff)) - 32'sh80000);
            2:       return {16'($urandom_range(0, 16'hffff)),
                             $urandom_range(0, 1) ? 16'hffff : 16'h0000};
            default: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000,
                             16'($urandom_range(0, 16'hffff))};
        endcase
    endfunction

    task random_points(int count);
        int hold;
        hold = $urandom_range(10, count - 10);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 3)
                calm = 1'b1;
            if (i == count / 2)
                calm = 1'b0;
            if (i == hold)
            begin
                // source holds off until the pipe is empty
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (sb.expected_noise.size() != 0)
                    @(posedge clk);
            end
            send_point(pick_coord(), pick_coord());
        end
        s_tvalid <= 1'b0;
    endtask

    task set_all(logic [3:0] o, logic [15:0] p, logic [15:0] l, logic [31:0] s);
        drain();
        reg_write(fvn_pkg::REG_OCTAVES, {28'd0, o});
        reg_write(fvn_pkg::REG_PERSISTENCE, {16'd0, p});
        reg_write(fvn_pkg::REG_LACUNARITY, {16'd0, l});
        reg_write(fvn_pkg::REG_SEED, s);
    endtask

    initial
    begin
        sb = new();
        calm = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        octaves_q = 4'd4;
        persist_q = 16'd32768;
        lacun_q = 16'd8192;
        seed_q = 32'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, extremes of the coordinates
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7fff_ffff, 32'h7fff_ffff);
        send_point(32'hffff_ffff, 32'h0000_ffff);
        send_point(32'h0000_ffff, 32'hffff_0000);
        send_point(32'h7fff_0000, 32'h8000_ffff);
        send_point(32'h0001_8000, 32'hfffe_8000);
        random_points(200);

        // zero octaves acts as one; zero persistence and lacunarity
        set_all(4'd0, 16'd0, 16'd0, 32'h0000_0001);
        send_point(32'h8000_0000, 32'h7fff_ffff);
        send_point(32'h1234_5678, 32'h8765_4321);
        random_points(150);

        // too many octaves, full persistence and lacunarity, seed wrap
        set_all(4'd15, 16'hffff, 16'hffff, 32'h7fff_fffd);
        send_point(32'h7fff_ffff, 32'h8000_0000);
        send_point(32'hffff_ffff, 32'hffff_ffff);
        random_points(200);

        set_all(4'd8, 16'd0, 16'hffff, 32'hffff_ffff);
        send_point(32'h0000_8000, 32'h0000_8000);
        random_points(150);

        set_all(4'd1, 16'hffff, 16'd0, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h0000_0000);
        random_points(150);

        set_all(4'd9, 16'd32768, 16'd4096, 32'hffff_fffe);
        random_points(120);

        for (int k = 0; k < 3; k++)
        begin
            set_all(4'($urandom_range(1, 8)), 16'($urandom()), 16'($urandom()), $urandom());
            random_points(110);
        end

        drain();
        if (sb.errors == 0)
            $display("fractal_value_noise_2d_unit_test: clean");
        else
            $display("fractal_value_noise_2d_unit_test: errors");
        $finish;
    end

endmodule
